// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/psp_pkg.sv =====
`default_nettype none

package psp_pkg;

  localparam int CH_IDX_W = 6;
  localparam int CFG_W    = 7;
  localparam logic [CFG_W-1:0] CH_COUNT_RESET = 7'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_STEP,
    ST_WAIT,
    ST_EMIT
  } state_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    SEL_BASE,
    SEL_STEP,
    SEL_ITER
  } mul_sel_t;

  typedef struct packed {
    logic                capture;
    logic                mul_go;
    mul_sel_t            sel;
    logic                out_load;
    logic [CH_IDX_W-1:0] out_index;
    logic                out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/baseline_phase_shift_phasor.sv =====
// Baseline phase-shift phasor generator.
// Input channel (in_valid/in_ready): one request per timeslot with the two
// station phasors and two step phasors, complex Q1.15. For each request the
// block emits channel_count results on the output channel (out_valid/
// out_ready): base*step^k for k = 0 .. n-1, with channel_index = k and last
// set on the final one. base = right*conj(left), step = right_step*conj(left_step).
// Config channel (cfg_valid/cfg_ready, ready whenever out of reset) writes
// channel_count; zero acts as one, values above MAX_CHANNELS clamp. Write it
// only when idle.
// Sequence: an accepted request passes the states BASE, STEP, WAIT and EMIT;
// each further result loops WAIT and EMIT, set by the recursive complex
// multiply (a register of products, then sum/round/saturate into the phasor
// register). A new request is taken while the last result still sits in the
// output register.
// A stalled receiver holds the output register and pauses the sequence.
// Reset (rst, synchronous) clears the sequencer and out_valid and sets
// channel_count to 1; both ready signals are low while rst is high.
`default_nettype none

module baseline_phase_shift_phasor import psp_pkg::*; #(
  parameter int MAX_CHANNELS = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [CFG_W-1:0]               cfg_data,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_im,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_im,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_step_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_step_im,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_step_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_step_im,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic signed [SAMPLE_WIDTH-1:0] out_re,
  output      logic signed [SAMPLE_WIDTH-1:0] out_im,
  output      logic [CH_IDX_W-1:0]            channel_index,
  output      logic                           last
);

  cmd_t    cmd;
  status_t status;

  psp_ctl #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  psp_dp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .left_re       (left_re),
    .left_im       (left_im),
    .right_re      (right_re),
    .right_im      (right_im),
    .left_step_re  (left_step_re),
    .left_step_im  (left_step_im),
    .right_step_re (right_step_re),
    .right_step_im (right_step_im),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_re        (out_re),
    .out_im        (out_im),
    .channel_index (channel_index),
    .last          (last)
  );

endmodule

`default_nettype wire

// ===== sv/psp_dp.sv =====
`default_nettype none

module psp_dp import psp_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cmd_t                           cmd,
  output      status_t                        status,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_im,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_im,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_step_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_step_im,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_step_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_step_im,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic signed [SAMPLE_WIDTH-1:0] out_re,
  output      logic signed [SAMPLE_WIDTH-1:0] out_im,
  output      logic [CH_IDX_W-1:0]            channel_index,
  output      logic                           last
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int PW    = 2 * W;
  localparam int SUM_W = 2 * W + 2;
  localparam logic signed [SUM_W-1:0] RND   = SUM_W'(1) << (W - 2);
  localparam logic signed [SUM_W-1:0] Q_MAX = (SUM_W'(1) << (W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] Q_MIN = -Q_MAX - SUM_W'(1);

  // round to nearest (ties up), drop W-1 fraction bits, saturate
  function automatic logic signed [W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = (s + RND) >>> (W - 1);
    if (q > Q_MAX) begin
      return Q_MAX[W-1:0];
    end else if (q < Q_MIN) begin
      return Q_MIN[W-1:0];
    end
    return q[W-1:0];
  endfunction

  logic signed [W-1:0] cap_left_re, cap_left_im, cap_right_re, cap_right_im;
  logic signed [W-1:0] cap_lstep_re, cap_lstep_im, cap_rstep_re, cap_rstep_im;
  logic signed [W-1:0] phasor_re, phasor_im, step_re, step_im;

  logic signed [W-1:0] a_re, a_im, b_re, b_im;
  logic                conj_b;

  logic signed [PW-1:0] prod_rr, prod_ii, prod_rb, prod_ib;
  logic                 pipe_valid;
  logic                 pipe_conj;
  mul_sel_t             pipe_sel;

  logic signed [SUM_W-1:0] re_sum, im_sum;
  logic signed [W-1:0]     re_rs, im_rs;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_left_re  <= left_re;
      cap_left_im  <= left_im;
      cap_right_re <= right_re;
      cap_right_im <= right_im;
      cap_lstep_re <= left_step_re;
      cap_lstep_im <= left_step_im;
      cap_rstep_re <= right_step_re;
      cap_rstep_im <= right_step_im;
    end
  end

  // a * b, or a * conj(b) for the station products
  always_comb begin
    case (cmd.sel)
      SEL_BASE: begin
        a_re = cap_right_re; a_im = cap_right_im;
        b_re = cap_left_re;  b_im = cap_left_im;
        conj_b = 1'b1;
      end
      SEL_STEP: begin
        a_re = cap_rstep_re; a_im = cap_rstep_im;
        b_re = cap_lstep_re; b_im = cap_lstep_im;
        conj_b = 1'b1;
      end
      SEL_ITER: begin
        a_re = phasor_re; a_im = phasor_im;
        b_re = step_re;   b_im = step_im;
        conj_b = 1'b0;
      end
      default: begin
        a_re = phasor_re; a_im = phasor_im;
        b_re = step_re;   b_im = step_im;
        conj_b = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    prod_rr   <= a_re * b_re;
    prod_ii   <= a_im * b_im;
    prod_rb   <= a_re * b_im;
    prod_ib   <= a_im * b_re;
    pipe_conj <= conj_b;
    pipe_sel  <= cmd.sel;
  end

  // conj flips the sign of b_im, so it turns the add/sub around
  always_comb begin
    if (pipe_conj) begin
      re_sum = SUM_W'(prod_rr) + SUM_W'(prod_ii);
      im_sum = SUM_W'(prod_ib) - SUM_W'(prod_rb);
    end else begin
      re_sum = SUM_W'(prod_rr) - SUM_W'(prod_ii);
      im_sum = SUM_W'(prod_ib) + SUM_W'(prod_rb);
    end
    re_rs = round_sat(re_sum);
    im_rs = round_sat(im_sum);
  end

  always_ff @(posedge clk) begin
    if (pipe_valid) begin
      if (pipe_sel == SEL_STEP) begin
        step_re <= re_rs;
        step_im <= im_rs;
      end else begin
        phasor_re <= re_rs;
        phasor_im <= im_rs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_re        <= phasor_re;
      out_im        <= phasor_im;
      channel_index <= cmd.out_index;
      last          <= cmd.out_last;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== sv/psp_ctl.sv =====
`default_nettype none
`include "assert_macros.svh"

module psp_ctl import psp_pkg::*; #(
  parameter int MAX_CHANNELS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire status_t          status,
  output      cmd_t             cmd
);

  localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_CHANNELS);

  state_t              state, state_next;
  logic [CFG_W-1:0]    channel_count;
  logic [CH_IDX_W-1:0] k, k_next;
  logic [CFG_W-1:0]    n_m1;
  logic                is_last;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CH_COUNT_RESET;
    end else if (cfg_valid) begin
      channel_count <= cfg_data;
    end
  end

  // zero counts as one channel, large counts clamp
  always_comb begin
    if (channel_count == '0) begin
      n_m1 = '0;
    end else if (channel_count > MAX_N) begin
      n_m1 = MAX_N - CFG_W'(1);
    end else begin
      n_m1 = channel_count - CFG_W'(1);
    end
    is_last = ({1'b0, k} == n_m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_BASE;
          k_next     = '0;
        end
      end
      ST_BASE: state_next = ST_STEP;
      ST_STEP: state_next = ST_WAIT;
      ST_WAIT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          if (is_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_WAIT;
            k_next     = k + CH_IDX_W'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.mul_go    = 1'b0;
    cmd.sel       = SEL_ITER;
    cmd.out_load  = 1'b0;
    cmd.out_index = k;
    cmd.out_last  = is_last;
    case (state)
      ST_IDLE: begin
        in_ready    = !rst;
        cmd.capture = in_valid;
      end
      ST_BASE: begin
        cmd.mul_go = 1'b1;
        cmd.sel    = SEL_BASE;
      end
      ST_STEP: begin
        cmd.mul_go = 1'b1;
        cmd.sel    = SEL_STEP;
      end
      ST_WAIT: ;
      ST_EMIT: begin
        // emit current term and, unless it is the last, start the next one in the same cycle
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.mul_go   = !is_last;
          cmd.sel      = SEL_ITER;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_load_needs_room, clk, rst, cmd.out_load, status.out_free)
  `ASSERT_IMPL(a_no_step_past_last, clk, rst, cmd.mul_go && cmd.sel == SEL_ITER,
               !is_last)
  `ASSERT_IMPL(a_index_in_range, clk, rst, state != ST_IDLE, {1'b0, k} <= n_m1)
  `ASSERT_NEXT(a_last_returns_idle, clk, rst, cmd.out_load && cmd.out_last,
               state == ST_IDLE)

endmodule

`default_nettype wire

// ===== bench/tb_baseline_phase_shift_phasor.sv =====
`timescale 1ns / 100ps

module tb_baseline_phase_shift_phasor;
  import psp_pkg::*;

  localparam int     CH_MAX      = 64;
  localparam longint Q15_MAX     = 32767;
  localparam longint Q15_MIN     = -32768;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     PHASE_ITEMS = 28;
  localparam int     PHASE_COUNT = 10;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    sample_t re;
    sample_t im;
  } cplx_t;

  typedef struct packed {
    cplx_t left;
    cplx_t right;
    cplx_t left_step;
    cplx_t right_step;
  } timeslot_t;

  typedef struct packed {
    sample_t             re;
    sample_t             im;
    logic [CH_IDX_W-1:0] idx;
    logic                last;
  } term_t;

  typedef enum logic [1:0] {
    PH_UNIT,
    PH_RANDOM,
    PH_EDGE
  } phasor_kind_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  timeslot_t        slot_bus = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  sample_t          out_re;
  sample_t          out_im;
  logic [CH_IDX_W-1:0] channel_index;
  logic             last;

  // predictor state
  logic [CFG_W-1:0] chan_count_cfg = CH_COUNT_RESET;
  sample_t          phase_re = '0;
  sample_t          phase_im = '0;
  sample_t          step_re = '0;
  sample_t          step_im = '0;

  term_t pending_terms[$];
  term_t want_term;
  int    error_count = 0;
  int    cycle_count = 0;
  int    burst_left = 0;
  int    rx_tick = 0;
  int    rx_hold = 1;
  rx_mode_t rx_mode = RX_STREAM;

  baseline_phase_shift_phasor uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .left_re       (slot_bus.left.re),
    .left_im       (slot_bus.left.im),
    .right_re      (slot_bus.right.re),
    .right_im      (slot_bus.right.im),
    .left_step_re  (slot_bus.left_step.re),
    .left_step_im  (slot_bus.left_step.im),
    .right_step_re (slot_bus.right_step.re),
    .right_step_im (slot_bus.right_step.im),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_re        (out_re),
    .out_im        (out_im),
    .channel_index (channel_index),
    .last          (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Q2.30 -> Q1.15: add half an LSB, floor shift, saturate
  function automatic sample_t round_q15(input longint wide);
    longint q;
    q = (wide + 64'sd16384) >>> 15;
    if (q > Q15_MAX) q = Q15_MAX;
    if (q < Q15_MIN) q = Q15_MIN;
    return sample_t'(q);
  endfunction

  function automatic void cplx_mul_q15(input longint ar, input longint ai,
                                       input longint br, input longint bi,
                                       output sample_t pr, output sample_t pi);
    pr = round_q15(ar * br - ai * bi);
    pi = round_q15(ar * bi + ai * br);
  endfunction

  task automatic predict_phase_terms(input timeslot_t ts);
    int      n;
    sample_t nr, ni;
    term_t   t;
    n = chan_count_cfg;
    if (n < 1) n = 1;
    if (n > CH_MAX) n = CH_MAX;
    // conj(left) negates im; -(-32768) needs the wide operand
    cplx_mul_q15(ts.right.re, ts.right.im, ts.left.re, -longint'(ts.left.im),
                 phase_re, phase_im);
    cplx_mul_q15(ts.right_step.re, ts.right_step.im, ts.left_step.re,
                 -longint'(ts.left_step.im), step_re, step_im);
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        cplx_mul_q15(phase_re, phase_im, step_re, step_im, nr, ni);
        phase_re = nr;
        phase_im = ni;
      end
      t.re   = phase_re;
      t.im   = phase_im;
      t.idx  = k[CH_IDX_W-1:0];
      t.last = (k == n - 1);
      pending_terms.push_back(t);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_terms.size() == 0) begin
        report_mismatch("unexpected result, channel_index", channel_index, -1);
      end else begin
        want_term = pending_terms.pop_front();
        if (out_re !== want_term.re) report_mismatch("out_re", out_re, want_term.re);
        if (out_im !== want_term.im) report_mismatch("out_im", out_im, want_term.im);
        if (channel_index !== want_term.idx)
          report_mismatch("channel_index", channel_index, want_term.idx);
        if (last !== want_term.last) report_mismatch("last", last, want_term.last);
      end
    end
  end

  // receiver: the stall pattern switches among stream, random and periodic modes
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 97 == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_hold = $urandom_range(1, 7);
    end
    case (rx_mode)
      RX_STREAM: out_ready = 1'b1;
      RX_RANDOM: out_ready = ($urandom_range(0, 3) != 0);
      default:   out_ready = ((rx_tick % 8) >= rx_hold);
    endcase
  end

  function automatic cplx_t pick_phasor(input phasor_kind_t kind);
    cplx_t c;
    real   ang;
    case (kind)
      PH_UNIT: begin
        ang = $urandom_range(0, 65535) * 6.283185307179586 / 65536.0;
        c.re = sample_t'($rtoi(32767.0 * $cos(ang)));
        c.im = sample_t'($rtoi(32767.0 * $sin(ang)));
      end
      PH_RANDOM: begin
        c.re = sample_t'($urandom);
        c.im = sample_t'($urandom);
      end
      default: begin
        for (int i = 0; i < 2; i++) begin
          case ($urandom_range(0, 5))
            0:       c.im = -16'sd32768;
            1:       c.im = -16'sd32767;
            2:       c.im = -16'sd1;
            3:       c.im = 16'sd0;
            4:       c.im = 16'sd1;
            default: c.im = 16'sd32767;
          endcase
          if (i == 0) c.re = c.im;
        end
      end
    endcase
    return c;
  endfunction

  function automatic timeslot_t random_slot();
    timeslot_t ts;
    cplx_t     p[4];
    int        r;
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70)      p[i] = pick_phasor(PH_UNIT);
      else if (r < 85) p[i] = pick_phasor(PH_RANDOM);
      else             p[i] = pick_phasor(PH_EDGE);
    end
    ts.left       = p[0];
    ts.right      = p[1];
    ts.left_step  = p[2];
    ts.right_step = p[3];
    return ts;
  endfunction

  function automatic timeslot_t make_slot(input sample_t lr, input sample_t li,
                                          input sample_t rr, input sample_t ri,
                                          input sample_t lsr, input sample_t lsi,
                                          input sample_t rsr, input sample_t rsi);
    timeslot_t ts;
    ts.left       = '{lr, li};
    ts.right      = '{rr, ri};
    ts.left_step  = '{lsr, lsi};
    ts.right_step = '{rsr, rsi};
    return ts;
  endfunction

  // valid stays high across a burst; the gap path or drain lowers it
  task automatic send_timeslot(input timeslot_t ts);
    @(negedge clk);
    slot_bus = ts;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_phase_terms(ts);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(0, 6);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
  endtask

  task automatic set_channel_count(input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chan_count_cfg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // count left at its reset value of one
  task automatic test_single_channel_extremes();
    send_timeslot(make_slot(0, 0, 0, 0, 0, 0, 0, 0));
    send_timeslot(make_slot(-32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, -32768));
    send_timeslot(make_slot(32767, 32767, 32767, 32767,
                            32767, 32767, 32767, 32767));
    send_timeslot(make_slot(-32768, -32768, 32767, -32768,
                            32767, -1, 1, -32767));
    send_timeslot(random_slot());
  endtask

  task automatic test_zero_count();
    set_channel_count(CFG_W'(0));
    send_timeslot(random_slot());
    send_timeslot(make_slot(32767, 0, 32767, 0, -32768, 0, 32767, 0));
  endtask

  task automatic test_count_clamp();
    set_channel_count(CFG_W'(127));
    send_timeslot(random_slot());
    set_channel_count(CFG_W'(65));
    send_timeslot(random_slot());
  endtask

  task automatic test_full_recursion();
    set_channel_count(CFG_W'(CH_MAX));
    // step saturates to just under one
    send_timeslot(make_slot(32767, 0, 0, 32767, -32768, 0, -32768, 0));
    send_timeslot(make_slot(-32768, 0, 23170, 23170, 32767, 0, 32767, 804));
    send_timeslot(random_slot());
  endtask

  task automatic test_short_counts();
    set_channel_count(CFG_W'(2));
    send_timeslot(make_slot(1, -1, -1, 1, -32768, 32767, 32767, -32768));
    send_timeslot(make_slot(-32767, 1, 0, -32768, 1, 0, 0, 1));
    set_channel_count(CFG_W'(3));
    send_timeslot(random_slot());
    send_timeslot(random_slot());
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] count;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        3:       count = CFG_W'(CH_MAX);
        6:       count = CFG_W'(127);
        8:       count = CFG_W'(0);
        default: count = CFG_W'($urandom_range(1, 12));
      endcase
      set_channel_count(count);
      for (int i = 0; i < PHASE_ITEMS; i++) send_timeslot(random_slot());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_single_channel_extremes();
    test_zero_count();
    test_count_clamp();
    test_full_recursion();
    test_short_counts();
    test_random_phases();
    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/psp_pkg.sv
sv/psp_dp.sv
sv/psp_ctl.sv
sv/baseline_phase_shift_phasor.sv
bench/tb_baseline_phase_shift_phasor.sv
